// ----- rtl/gregorian_day_number_converter_assert.svh -----
// ----------------------------------------------------------------------------
// Gregorian day number converter assertion macros
// Concurrent checks shared by the converter RTL, one macro per check shape.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH
`define GREGORIAN_DAY_NUMBER_CONVERTER_ASSERT_SVH

// Checks that expr holds in the same cycle as cond.
`define GDNC_ASSERT_IMPLY(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("gdnc: same-cycle check failed");

// Checks that expr holds after cond, delayed by the macro argument n.
`define GDNC_ASSERT_AFTER(label, clk, rst, cond, n, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> ##(n) (expr)) \
      else $error("gdnc: delayed check failed");

`endif

// ----- rtl/gdnc_pkg.sv -----
// ----------------------------------------------------------------------------
// Gregorian day number converter package
// Types, calendar constants and small tables for the day number pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gdnc_pkg;

   typedef enum logic [1:0] {
      OP_TO_DAYS  = 2'd0,
      OP_TO_DATE  = 2'd1,
      OP_ADD_DAYS = 2'd2,
      OP_DIFF     = 2'd3
   } op_type;

   localparam logic CSR_EPOCH = 1'b0;

   localparam int unsigned RSP_DELAY = 13;

   localparam logic [21:0] EPOCH_RESET = 22'd2440588;

   localparam logic signed [14:0] YEAR_MIN = -15'sd4799;
   localparam logic signed [14:0] YEAR_MAX = 15'sd9999;
   localparam logic [15:0] YEAR_BIAS = 16'd4800;

   localparam logic [15:0] JDN_BIAS = 16'd32045;
   localparam logic [15:0] JUL_BIAS = 16'd32044;
   localparam logic signed [24:0] JDN_LO = -25'sd31738;
   localparam logic signed [24:0] JDN_HI = 25'sd5373484;

   localparam logic signed [25:0] CNT_MAX = 26'sd8388607;
   localparam logic signed [25:0] CNT_MIN = -26'sd8388608;

   localparam int unsigned DIV100_SHIFT = 24;
   localparam logic [17:0] DIV100_RECIP =
      18'(((64'd1 << DIV100_SHIFT) + 64'd99) / 64'd100);

   localparam logic [17:0] ERA_DAYS = 18'd146097;
   localparam int unsigned ERA_SHIFT = 41;
   localparam logic [23:0] ERA_RECIP =
      24'(((64'd1 << ERA_SHIFT) + 64'd146096) / 64'd146097);

   localparam logic [15:0] CENT_DAYS = 16'd36524;

   localparam logic [10:0] QUAD_DAYS = 11'd1461;
   localparam int unsigned QUAD_SHIFT = 26;
   localparam logic [15:0] QUAD_RECIP =
      16'(((64'd1 << QUAD_SHIFT) + 64'd1460) / 64'd1461);

   localparam logic [8:0] YEAR_DAYS = 9'd365;

   localparam int unsigned MONTH_SPAN = 153;
   localparam logic [11:0] MONTH_NUM_BIAS = 12'd308;

   typedef struct packed {
      logic       ok;
      logic [13:0] yp;
      logic [8:0]  md;
   } date_type;

   typedef struct packed {
      logic        ok;
      logic [7:0]  q100;
      logic [22:0] base;
   } jsum_type;

   typedef struct packed {
      op_type      op;
      logic        bad;
      logic        lo;
      logic        hi;
      logic [23:0] count;
      logic        earlier;
      logic        same;
   } ctl_type;

   typedef struct packed {
      logic [5:0] era;
      logic [1:0] cent;
      logic [4:0] quad;
      logic [1:0] yr;
   } civ_type;

   // Day offset of a month counted from March, (153 * m + 2) / 5.
   function automatic logic [8:0] march_offset(input logic [3:0] mp);
      logic [8:0] r;
      unique case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Range check and March-based year and month offsets of one date.
   function automatic date_type prep_date(input logic [3:0] mon, input logic [4:0] dom,
                                          input logic signed [14:0] yr);
      logic             early;
      logic signed [15:0] ys;
      logic [3:0]       mp;
      date_type         r;
      early = (mon <= 4'd2);
      ys = $signed({yr[14], yr}) + $signed(YEAR_BIAS) - $signed({15'd0, early});
      mp = early ? (mon + 4'd9) : (mon - 4'd3);
      r.ok = (mon >= 4'd1) && (mon <= 4'd12) && (dom != 5'd0) &&
             (yr >= YEAR_MIN) && (yr <= YEAR_MAX);
      r.yp = ys[13:0];
      r.md = 9'(dom) + march_offset(mp);
      return r;
   endfunction

endpackage

// ----- rtl/gregorian_day_number_converter.sv -----
// ----------------------------------------------------------------------------
// Gregorian day number converter
// Pipelined proleptic Gregorian date arithmetic on Julian day numbers.
// ----------------------------------------------------------------------------
// A word is accepted on the req ports at a rising edge with start high and
// busy low; busy is always low, so one word may enter in every cycle.
// Each word gives one result word on the rsp ports, marked by rsp_valid for
// exactly one cycle. rsp_valid rises in the same cycle as the result word
// appears on the rsp ports; throughput is one word per cycle. A word passes
// through thirteen register stages: date offsets, the century divide, day
// number assembly, operand select, range and count saturation, and the era,
// century, four-year, year and month steps of the day number to date
// conversion, the last being the output register.
// The receiver cannot stall, so results never wait.
// The epoch offset lives at byte address 0 of the APB-style port and is to be
// written by the user only while no word is in flight; the block does not enforce it.
// Synchronous reset empties the pipeline and restores the epoch offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gregorian_day_number_converter_assert.svh"

module gregorian_day_number_converter (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic signed [14:0] req_year,
   input  logic signed [22:0] req_day_count_in,
   input  logic [3:0]         req_month_b,
   input  logic [4:0]         req_day_b,
   input  logic signed [14:0] req_year_b,
   output logic               rsp_valid,
   output logic signed [23:0] rsp_day_count_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_day_out,
   output logic signed [14:0] rsp_year_out,
   output logic               rsp_earlier,
   output logic               rsp_same_date,
   output logic               rsp_invalid,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   logic [21:0] epoch_ff, epoch_in;
   logic [12:0] valid_ff, valid_in;

   gdnc_pkg::op_type   s1_op_ff, s1_op_in;
   logic signed [22:0] s1_cnt_ff, s1_cnt_in;
   gdnc_pkg::date_type s1_a_ff, s1_a_in, s1_b_ff, s1_b_in;

   gdnc_pkg::op_type   s2_op_ff;
   logic signed [22:0] s2_cnt_ff;
   gdnc_pkg::jsum_type s2_a_ff, s2_a_in, s2_b_ff, s2_b_in;

   gdnc_pkg::op_type   s3_op_ff;
   logic signed [22:0] s3_cnt_ff;
   logic               s3_oka_ff, s3_okb_ff;
   logic signed [24:0] s3_ja_ff, s3_ja_in, s3_jb_ff, s3_jb_in;

   gdnc_pkg::op_type   s4_op_ff;
   logic signed [22:0] s4_cnt_ff;
   logic               s4_bad_ff, s4_bad_in;
   logic signed [24:0] s4_j_ff, s4_j_in;
   logic [23:0]        s4_diff_ff, s4_diff_in;

   gdnc_pkg::ctl_type  s5_ctl_ff, s5_ctl_in;
   logic [22:0]        s5_jul_ff, s5_jul_in;

   gdnc_pkg::ctl_type  s6_ctl_ff;
   logic [22:0]        s6_jul_ff;
   logic [5:0]         s6_era_ff, s6_era_in;

   gdnc_pkg::ctl_type  s7_ctl_ff;
   logic [5:0]         s7_era_ff;
   logic [17:0]        s7_dg_ff, s7_dg_in;

   gdnc_pkg::ctl_type  s8_ctl_ff;
   gdnc_pkg::civ_type  s8_civ_ff, s8_civ_in;
   logic [15:0]        s8_dc_ff, s8_dc_in;

   gdnc_pkg::ctl_type  s9_ctl_ff;
   gdnc_pkg::civ_type  s9_civ_ff, s9_civ_in;
   logic [15:0]        s9_dc_ff;

   gdnc_pkg::ctl_type  s10_ctl_ff;
   gdnc_pkg::civ_type  s10_civ_ff;
   logic [10:0]        s10_db_ff, s10_db_in;

   gdnc_pkg::ctl_type  s11_ctl_ff;
   gdnc_pkg::civ_type  s11_civ_ff, s11_civ_in;
   logic [8:0]         s11_dd_ff, s11_dd_in;

   gdnc_pkg::ctl_type  s12_ctl_ff;
   gdnc_pkg::civ_type  s12_civ_ff;
   logic [8:0]         s12_dd_ff;
   logic [3:0]         s12_m_ff, s12_m_in;

   logic signed [23:0] rsp_count_ff, rsp_count_in;
   logic [3:0]         rsp_month_ff, rsp_month_in;
   logic [4:0]         rsp_day_ff, rsp_day_in;
   logic signed [14:0] rsp_year_ff, rsp_year_in;
   logic               rsp_earlier_ff, rsp_earlier_in;
   logic               rsp_same_ff, rsp_same_in;
   logic               rsp_invalid_ff, rsp_invalid_in;

   logic        csr_write;
   logic [31:0] s2_pa, s2_pb;
   logic [46:0] s6_prod;
   logic [31:0] s9_prod;
   logic signed [25:0] s5_rel;
   logic [23:0] s5_sat;
   logic [11:0] s12_num;
   logic [15:0] s13_ysum;
   logic [3:0]  s13_month;
   logic [4:0]  s13_day;
   logic [14:0] s13_year;

   assign busy   = 1'b0;
   assign pready = 1'b1;

   assign csr_write = psel && penable && pwrite && (paddr[2] == gdnc_pkg::CSR_EPOCH);
   assign epoch_in  = csr_write ? pwdata[21:0] : epoch_ff;
   assign prdata    = (paddr[2] == gdnc_pkg::CSR_EPOCH) ? {10'd0, epoch_ff} : 32'd0;

   assign valid_in = {valid_ff[11:0], start && !busy};

   always_comb begin
      s1_op_in  = gdnc_pkg::op_type'(req_opcode);
      s1_cnt_in = req_day_count_in;
      s1_a_in   = gdnc_pkg::prep_date(req_month, req_day, req_year);
      s1_b_in   = gdnc_pkg::prep_date(req_month_b, req_day_b, req_year_b);
   end

   always_comb begin
      s2_pa = {18'd0, s1_a_ff.yp} * {14'd0, gdnc_pkg::DIV100_RECIP};
      s2_pb = {18'd0, s1_b_ff.yp} * {14'd0, gdnc_pkg::DIV100_RECIP};
      s2_a_in.ok   = s1_a_ff.ok;
      s2_a_in.q100 = s2_pa[31:24];
      s2_a_in.base = 23'(s1_a_ff.md) + 23'(s1_a_ff.yp) * 23'(gdnc_pkg::YEAR_DAYS) +
                     23'(s1_a_ff.yp[13:2]);
      s2_b_in.ok   = s1_b_ff.ok;
      s2_b_in.q100 = s2_pb[31:24];
      s2_b_in.base = 23'(s1_b_ff.md) + 23'(s1_b_ff.yp) * 23'(gdnc_pkg::YEAR_DAYS) +
                     23'(s1_b_ff.yp[13:2]);
   end

   always_comb begin
      s3_ja_in = $signed({2'd0, s2_a_ff.base}) - $signed({17'd0, s2_a_ff.q100}) +
                 $signed({19'd0, s2_a_ff.q100[7:2]}) - $signed({9'd0, gdnc_pkg::JDN_BIAS});
      s3_jb_in = $signed({2'd0, s2_b_ff.base}) - $signed({17'd0, s2_b_ff.q100}) +
                 $signed({19'd0, s2_b_ff.q100[7:2]}) - $signed({9'd0, gdnc_pkg::JDN_BIAS});
   end

   always_comb begin
      unique case (s3_op_ff)
         gdnc_pkg::OP_TO_DATE: begin
            s4_j_in   = $signed({{2{s3_cnt_ff[22]}}, s3_cnt_ff}) + $signed({3'd0, epoch_ff});
            s4_bad_in = 1'b0;
         end
         gdnc_pkg::OP_ADD_DAYS: begin
            s4_j_in   = s3_ja_ff + $signed({{2{s3_cnt_ff[22]}}, s3_cnt_ff});
            s4_bad_in = !s3_oka_ff;
         end
         gdnc_pkg::OP_DIFF: begin
            s4_j_in   = s3_ja_ff;
            s4_bad_in = !(s3_oka_ff && s3_okb_ff);
         end
         gdnc_pkg::OP_TO_DAYS: begin
            s4_j_in   = s3_ja_ff;
            s4_bad_in = !s3_oka_ff;
         end
         default: begin
            s4_j_in   = s3_ja_ff;
            s4_bad_in = 1'b1;
         end
      endcase
      s4_diff_in = s3_ja_ff[23:0] - s3_jb_ff[23:0];
   end

   always_comb begin
      s5_rel = $signed({s4_j_ff[24], s4_j_ff}) - $signed({4'd0, epoch_ff});
      priority if (s5_rel > gdnc_pkg::CNT_MAX) begin
         s5_sat = 24'h7FFFFF;
      end else if (s5_rel < gdnc_pkg::CNT_MIN) begin
         s5_sat = 24'h800000;
      end else begin
         s5_sat = s5_rel[23:0];
      end
      s5_ctl_in.op      = s4_op_ff;
      s5_ctl_in.bad     = s4_bad_ff;
      s5_ctl_in.lo      = s4_j_ff < gdnc_pkg::JDN_LO;
      s5_ctl_in.hi      = s4_j_ff > gdnc_pkg::JDN_HI;
      s5_ctl_in.earlier = !s4_bad_ff && (s4_op_ff == gdnc_pkg::OP_DIFF) && s4_diff_ff[23];
      s5_ctl_in.same    = !s4_bad_ff && (s4_op_ff == gdnc_pkg::OP_DIFF) &&
                          (s4_diff_ff == 24'd0);
      priority if (s4_bad_ff) begin
         s5_ctl_in.count = 24'd0;
      end else if (s4_op_ff == gdnc_pkg::OP_TO_DATE) begin
         s5_ctl_in.count = {s4_cnt_ff[22], s4_cnt_ff};
      end else if (s4_op_ff == gdnc_pkg::OP_DIFF) begin
         s5_ctl_in.count = s4_diff_ff;
      end else begin
         s5_ctl_in.count = s5_sat;
      end
      s5_jul_in = s4_j_ff[22:0] + 23'(gdnc_pkg::JUL_BIAS);
   end

   always_comb begin
      s6_prod   = {24'd0, s5_jul_ff} * {23'd0, gdnc_pkg::ERA_RECIP};
      s6_era_in = s6_prod[46:41];
   end

   assign s7_dg_in = 18'(s6_jul_ff - 23'(s6_era_ff) * 23'(gdnc_pkg::ERA_DAYS));

   always_comb begin
      s8_civ_in.era  = s7_era_ff;
      s8_civ_in.cent = 2'(s7_dg_ff >= 18'(gdnc_pkg::CENT_DAYS)) +
                       2'(s7_dg_ff >= 18'(gdnc_pkg::CENT_DAYS) * 18'd2) +
                       2'(s7_dg_ff >= 18'(gdnc_pkg::CENT_DAYS) * 18'd3);
      s8_civ_in.quad = 5'd0;
      s8_civ_in.yr   = 2'd0;
      s8_dc_in = 16'(s7_dg_ff - 18'(s8_civ_in.cent) * 18'(gdnc_pkg::CENT_DAYS));
   end

   always_comb begin
      s9_prod        = {16'd0, s8_dc_ff} * {16'd0, gdnc_pkg::QUAD_RECIP};
      s9_civ_in      = s8_civ_ff;
      s9_civ_in.quad = s9_prod[30:26];
   end

   assign s10_db_in = 11'(s9_dc_ff - 16'(s9_civ_ff.quad) * 16'(gdnc_pkg::QUAD_DAYS));

   always_comb begin
      s11_civ_in    = s10_civ_ff;
      s11_civ_in.yr = 2'(s10_db_ff >= 11'(gdnc_pkg::YEAR_DAYS)) +
                      2'(s10_db_ff >= 11'(gdnc_pkg::YEAR_DAYS) * 11'd2) +
                      2'(s10_db_ff >= 11'(gdnc_pkg::YEAR_DAYS) * 11'd3);
      s11_dd_in = 9'(s10_db_ff - 11'(s11_civ_in.yr) * 11'(gdnc_pkg::YEAR_DAYS));
   end

   always_comb begin
      s12_num  = 12'(s11_dd_ff) * 12'd5 + gdnc_pkg::MONTH_NUM_BIAS;
      s12_m_in = 4'd0;
      for (int k = 1; k <= 11; k++) begin
         s12_m_in = s12_m_in + 4'(s12_num >= 12'(gdnc_pkg::MONTH_SPAN * (k + 2)));
      end
   end

   always_comb begin
      s13_ysum = 16'(s12_civ_ff.era) * 16'd400 + 16'(s12_civ_ff.cent) * 16'd100 +
                 16'(s12_civ_ff.quad) * 16'd4 + 16'(s12_civ_ff.yr);
      s13_year = 15'(s13_ysum - gdnc_pkg::YEAR_BIAS + 16'(s12_m_ff >= 4'd10));
      s13_month = (s12_m_ff >= 4'd10) ? (s12_m_ff - 4'd9) : (s12_m_ff + 4'd3);
      s13_day = 5'(s12_dd_ff - gdnc_pkg::march_offset(s12_m_ff) + 9'd1);

      rsp_count_in   = s12_ctl_ff.count;
      rsp_earlier_in = s12_ctl_ff.earlier;
      rsp_same_in    = s12_ctl_ff.same;
      priority if (s12_ctl_ff.bad) begin
         rsp_month_in   = 4'd0;
         rsp_day_in     = 5'd0;
         rsp_year_in    = 15'sd0;
         rsp_invalid_in = 1'b1;
      end else if (s12_ctl_ff.op == gdnc_pkg::OP_DIFF) begin
         rsp_month_in   = 4'd0;
         rsp_day_in     = 5'd0;
         rsp_year_in    = 15'sd0;
         rsp_invalid_in = 1'b0;
      end else if (s12_ctl_ff.lo) begin
         rsp_month_in   = 4'd1;
         rsp_day_in     = 5'd1;
         rsp_year_in    = gdnc_pkg::YEAR_MIN;
         rsp_invalid_in = 1'b1;
      end else if (s12_ctl_ff.hi) begin
         rsp_month_in   = 4'd12;
         rsp_day_in     = 5'd31;
         rsp_year_in    = gdnc_pkg::YEAR_MAX;
         rsp_invalid_in = 1'b1;
      end else begin
         rsp_month_in   = s13_month;
         rsp_day_in     = s13_day;
         rsp_year_in    = $signed(s13_year);
         rsp_invalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff <= gdnc_pkg::EPOCH_RESET;
         valid_ff <= '0;
      end else begin
         epoch_ff <= epoch_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff  <= s1_op_in;
      s1_cnt_ff <= s1_cnt_in;
      s1_a_ff   <= s1_a_in;
      s1_b_ff   <= s1_b_in;

      s2_op_ff  <= s1_op_ff;
      s2_cnt_ff <= s1_cnt_ff;
      s2_a_ff   <= s2_a_in;
      s2_b_ff   <= s2_b_in;

      s3_op_ff  <= s2_op_ff;
      s3_cnt_ff <= s2_cnt_ff;
      s3_oka_ff <= s2_a_ff.ok;
      s3_okb_ff <= s2_b_ff.ok;
      s3_ja_ff  <= s3_ja_in;
      s3_jb_ff  <= s3_jb_in;

      s4_op_ff   <= s3_op_ff;
      s4_cnt_ff  <= s3_cnt_ff;
      s4_bad_ff  <= s4_bad_in;
      s4_j_ff    <= s4_j_in;
      s4_diff_ff <= s4_diff_in;

      s5_ctl_ff <= s5_ctl_in;
      s5_jul_ff <= s5_jul_in;

      s6_ctl_ff <= s5_ctl_ff;
      s6_jul_ff <= s5_jul_ff;
      s6_era_ff <= s6_era_in;

      s7_ctl_ff <= s6_ctl_ff;
      s7_era_ff <= s6_era_ff;
      s7_dg_ff  <= s7_dg_in;

      s8_ctl_ff <= s7_ctl_ff;
      s8_civ_ff <= s8_civ_in;
      s8_dc_ff  <= s8_dc_in;

      s9_ctl_ff <= s8_ctl_ff;
      s9_civ_ff <= s9_civ_in;
      s9_dc_ff  <= s8_dc_ff;

      s10_ctl_ff <= s9_ctl_ff;
      s10_civ_ff <= s9_civ_ff;
      s10_db_ff  <= s10_db_in;

      s11_ctl_ff <= s10_ctl_ff;
      s11_civ_ff <= s11_civ_in;
      s11_dd_ff  <= s11_dd_in;

      s12_ctl_ff <= s11_ctl_ff;
      s12_civ_ff <= s11_civ_ff;
      s12_dd_ff  <= s11_dd_ff;
      s12_m_ff   <= s12_m_in;

      rsp_count_ff   <= rsp_count_in;
      rsp_month_ff   <= rsp_month_in;
      rsp_day_ff     <= rsp_day_in;
      rsp_year_ff    <= rsp_year_in;
      rsp_earlier_ff <= rsp_earlier_in;
      rsp_same_ff    <= rsp_same_in;
      rsp_invalid_ff <= rsp_invalid_in;
   end

   assign rsp_valid         = valid_ff[12];
   assign rsp_day_count_out = rsp_count_ff;
   assign rsp_month_out     = rsp_month_ff;
   assign rsp_day_out       = rsp_day_ff;
   assign rsp_year_out      = rsp_year_ff;
   assign rsp_earlier       = rsp_earlier_ff;
   assign rsp_same_date     = rsp_same_ff;
   assign rsp_invalid       = rsp_invalid_ff;

   `GDNC_ASSERT_AFTER(a_word_latency, clock, reset, start && !busy, gdnc_pkg::RSP_DELAY, rsp_valid)
   `GDNC_ASSERT_IMPLY(a_diff_has_no_date, clock, reset, rsp_valid && (rsp_earlier || rsp_same_date), (rsp_month_out == 4'd0) && !rsp_invalid && !(rsp_earlier && rsp_same_date))
   `GDNC_ASSERT_IMPLY(a_date_in_range, clock, reset, rsp_valid && !rsp_invalid && (rsp_month_out != 4'd0), (rsp_month_out <= 4'd12) && (rsp_day_out != 5'd0))

endmodule

// ----- dv/gdnc_checker.sv -----
// ----------------------------------------------------------------------------
// Gregorian day number converter checker
// Watches the request, result and register ports of the converter. For each
// accepted word it predicts the result with its own day number arithmetic
// and a shadow of the epoch offset. It compares every result word field by
// field with the oldest prediction, and it checks register reads against the
// shadow.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gdnc_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic               busy,
   input  logic [1:0]         req_opcode,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic signed [14:0] req_year,
   input  logic signed [22:0] req_day_count_in,
   input  logic [3:0]         req_month_b,
   input  logic [4:0]         req_day_b,
   input  logic signed [14:0] req_year_b,
   input  logic               rsp_valid,
   input  logic signed [23:0] rsp_day_count_out,
   input  logic [3:0]         rsp_month_out,
   input  logic [4:0]         rsp_day_out,
   input  logic signed [14:0] rsp_year_out,
   input  logic               rsp_earlier,
   input  logic               rsp_same_date,
   input  logic               rsp_invalid,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   input  logic [31:0]        prdata,
   input  logic               pready,
   output int                 error_count,
   output int                 results_pending
);

   localparam logic [2:0] EPOCH_ADDR = {gdnc_pkg::CSR_EPOCH, 2'b00};
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic signed [23:0] count;
      logic [3:0]         month;
      logic [4:0]         day;
      logic signed [14:0] year;
      logic               earlier;
      logic               same_date;
      logic               invalid;
   } date_word_type;

   logic [21:0]   epoch_shadow;
   date_word_type expected_words[$];
   int            mismatches = 0;

   function automatic longint day_number(input longint mon, input longint dom,
                                         input longint yr);
      longint a;
      longint yy;
      longint mm;
      a = (14 - mon) / 12;
      yy = yr + 4800 - a;
      mm = mon + 12 * a - 3;
      return dom + (153 * mm + 2) / 5 + 365 * yy + yy / 4 - yy / 100 + yy / 400 - 32045;
   endfunction

   function automatic bit date_ok(input longint mon, input longint dom, input longint yr);
      return mon >= 1 && mon <= 12 && dom >= 1 && dom <= 31 &&
             yr >= gdnc_pkg::YEAR_MIN && yr <= gdnc_pkg::YEAR_MAX;
   endfunction

   // Returns 0 when the day number lies outside the supported years; the date
   // is then pinned to the nearest end of the range.
   function automatic bit civil_date(input longint jdn, output longint mon,
                                     output longint dom, output longint yr);
      longint jul, g, dg, c, dc, b, db, a, dd, y, m, d;
      if (jdn < day_number(1, 1, gdnc_pkg::YEAR_MIN)) begin
         mon = 1;
         dom = 1;
         yr = gdnc_pkg::YEAR_MIN;
         return 1'b0;
      end
      if (jdn > day_number(12, 31, gdnc_pkg::YEAR_MAX)) begin
         mon = 12;
         dom = 31;
         yr = gdnc_pkg::YEAR_MAX;
         return 1'b0;
      end
      jul = jdn + 32044;
      g = jul / 146097;
      dg = jul % 146097;
      c = (dg / 36524 + 1) * 3 / 4;
      dc = dg - c * 36524;
      b = dc / 1461;
      db = dc % 1461;
      a = (db / 365 + 1) * 3 / 4;
      dd = db - a * 365;
      y = g * 400 + c * 100 + b * 4 + a;
      m = (dd * 5 + 308) / 153 - 2;
      d = dd - (m + 4) * 153 / 5 + 122;
      yr = y - 4800 + (m + 2) / 12;
      mon = (m + 2) % 12 + 1;
      dom = d + 1;
      return 1'b1;
   endfunction

   function automatic longint clamp_count(input longint v);
      if (v < gdnc_pkg::CNT_MIN) return gdnc_pkg::CNT_MIN;
      if (v > gdnc_pkg::CNT_MAX) return gdnc_pkg::CNT_MAX;
      return v;
   endfunction

   function automatic date_word_type convert_date(input gdnc_pkg::op_type op,
                                                  input longint m,
                                                  input longint d, input longint y,
                                                  input longint cnt, input longint mb,
                                                  input longint db, input longint yb,
                                                  input longint ep);
      date_word_type r;
      longint        j, c, mo, da, ye;
      r = '0;
      c = 0;
      mo = 0;
      da = 0;
      ye = 0;
      if (op == gdnc_pkg::OP_TO_DATE) begin
         r.invalid = !civil_date(cnt + ep, mo, da, ye);
         c = cnt;
      end else if (!date_ok(m, d, y) ||
                   (op == gdnc_pkg::OP_DIFF && !date_ok(mb, db, yb))) begin
         r.invalid = 1'b1;
      end else if (op == gdnc_pkg::OP_DIFF) begin
         c = clamp_count(day_number(m, d, y) - day_number(mb, db, yb));
         r.earlier = c < 0;
         r.same_date = c == 0;
      end else begin
         j = day_number(m, d, y);
         if (op == gdnc_pkg::OP_ADD_DAYS) j = j + cnt;
         r.invalid = !civil_date(j, mo, da, ye);
         c = clamp_count(j - ep);
      end
      r.count = c[23:0];
      r.month = mo[3:0];
      r.day = da[4:0];
      r.year = ye[14:0];
      return r;
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("%0t: %s", $realtime, msg);
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (got !== want)
         report($sformatf("%s mismatch: expected %0d, got %0d", name,
                          $signed(want), $signed(got)));
   endtask

   always @(posedge clock) begin : monitor
      date_word_type want;
      if (reset) begin
         expected_words.delete();
         epoch_shadow = gdnc_pkg::EPOCH_RESET;
      end else begin
         if (psel && penable && pready && paddr == EPOCH_ADDR) begin
            if (pwrite) begin
               epoch_shadow = pwdata[21:0];
            end else if (prdata !== {10'd0, epoch_shadow}) begin
               report($sformatf("epoch read mismatch: expected %0d, got %0d",
                                epoch_shadow, prdata));
            end
         end
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               report("result word with no word pending");
            end else begin
               want = expected_words.pop_front();
               check_field("day_count_out", $signed(want.count), $signed(rsp_day_count_out));
               check_field("month_out", want.month, rsp_month_out);
               check_field("day_out", want.day, rsp_day_out);
               check_field("year_out", $signed(want.year), $signed(rsp_year_out));
               check_field("earlier", want.earlier, rsp_earlier);
               check_field("same_date", want.same_date, rsp_same_date);
               check_field("invalid", want.invalid, rsp_invalid);
            end
         end
         if (start && !busy)
            expected_words.push_back(convert_date(gdnc_pkg::op_type'(req_opcode),
                                                  req_month, req_day,
                                                  req_year, req_day_count_in, req_month_b,
                                                  req_day_b, req_year_b, epoch_shadow));
      end
      error_count <= mismatches;
      results_pending <= expected_words.size();
   end

endmodule

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Gregorian day number converter testbench
// Drives directed edge dates and bursts of random words through the
// converter under several epoch offsets, with random gaps between bursts and
// a full drain before every register write. A separate checker predicts and
// compares every result word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

   localparam int WORDS_PER_PHASE = 180;
   localparam int CYCLE_LIMIT = 200000;
   localparam logic [2:0] EPOCH_ADDR = {gdnc_pkg::CSR_EPOCH, 2'b00};

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [1:0]         req_opcode;
   logic [3:0]         req_month;
   logic [4:0]         req_day;
   logic signed [14:0] req_year;
   logic signed [22:0] req_day_count_in;
   logic [3:0]         req_month_b;
   logic [4:0]         req_day_b;
   logic signed [14:0] req_year_b;
   logic               rsp_valid;
   logic signed [23:0] rsp_day_count_out;
   logic [3:0]         rsp_month_out;
   logic [4:0]         rsp_day_out;
   logic signed [14:0] rsp_year_out;
   logic               rsp_earlier;
   logic               rsp_same_date;
   logic               rsp_invalid;
   logic               psel;
   logic               penable;
   logic               pwrite;
   logic [2:0]         paddr;
   logic [31:0]        pwdata;
   logic [31:0]        prdata;
   logic               pready;
   int                 error_count;
   int                 results_pending;
   logic [21:0]        current_epoch;

   gregorian_day_number_converter dut (.*);

   gdnc_checker date_checker (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin : watchdog
      int cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAILURE");
      $finish;
   end

   task automatic send_word(input gdnc_pkg::op_type op, input logic [3:0] m,
                            input logic [4:0] d,
                            input logic signed [14:0] y, input logic signed [22:0] cnt,
                            input logic [3:0] mb, input logic [4:0] db,
                            input logic signed [14:0] yb);
      @(negedge clock);
      start <= 1'b1;
      req_opcode <= op;
      req_month <= m;
      req_day <= d;
      req_year <= y;
      req_day_count_in <= cnt;
      req_month_b <= mb;
      req_day_b <= db;
      req_year_b <= yb;
      do @(posedge clock); while (busy);
   endtask

   task automatic idle(input int n);
      repeat (n) begin
         @(negedge clock);
         start <= 1'b0;
      end
   endtask

   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (results_pending != 0) @(negedge clock);
   endtask

   task automatic load_epoch(input logic [31:0] v);
      @(negedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= EPOCH_ADDR;
      pwdata <= v;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      current_epoch = v[21:0];
      @(negedge clock);
      psel <= 1'b1;
      pwrite <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic directed_words();
      send_word(gdnc_pkg::OP_TO_DAYS, 1, 1, 1970, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 1, 1, -4799, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 12, 31, 9999, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 2, 29, 1900, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 2, 29, 2000, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 2, 31, 2001, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 0, 15, 2000, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 13, 15, 2000, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 15, 31, 2000, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 6, 0, 2000, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 6, 30, -4800, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 6, 30, 10000, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 6, 1, -16384, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0,
                23'(gdnc_pkg::JDN_LO - 1 - gdnc_pkg::EPOCH_RESET), 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0,
                23'(gdnc_pkg::JDN_HI - gdnc_pkg::EPOCH_RESET), 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 15, 31, -1, -4194304, 15, 31, -1);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0, 4194303, 0, 0, 0);
      send_word(gdnc_pkg::OP_ADD_DAYS, 12, 31, 9999, 1, 0, 0, 0);
      send_word(gdnc_pkg::OP_ADD_DAYS, 1, 1, -4799, -1, 0, 0, 0);
      send_word(gdnc_pkg::OP_ADD_DAYS, 2, 28, 2024, 366, 0, 0, 0);
      send_word(gdnc_pkg::OP_ADD_DAYS, 13, 1, 2024, 5, 0, 0, 0);
      send_word(gdnc_pkg::OP_DIFF, 3, 1, 2024, 0, 3, 1, 2024);
      send_word(gdnc_pkg::OP_DIFF, 1, 1, -4799, 0, 12, 31, 9999);
      send_word(gdnc_pkg::OP_DIFF, 12, 31, 9999, 0, 1, 1, -4799);
      send_word(gdnc_pkg::OP_DIFF, 7, 4, 1776, 0, 7, 0, 1776);
      send_word(gdnc_pkg::OP_DIFF, 14, 4, 1776, 0, 7, 4, 1776);
   endtask

   // Range ends and count saturation depend on the epoch, so these run in
   // every phase.
   task automatic edge_words();
      send_word(gdnc_pkg::OP_ADD_DAYS, 12, 31, 9999, 4194303, 0, 0, 0);
      send_word(gdnc_pkg::OP_ADD_DAYS, 1, 1, -4799, -4194304, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0, -4194304, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0, 4194303, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0, 23'(gdnc_pkg::JDN_LO - current_epoch),
                0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DATE, 0, 0, 0, 23'(gdnc_pkg::JDN_HI - current_epoch),
                0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 12, 31, 9999, 0, 0, 0, 0);
      send_word(gdnc_pkg::OP_TO_DAYS, 1, 1, -4799, 0, 0, 0, 0);
   endtask

   task automatic random_date(output logic [3:0] m, output logic [4:0] d,
                              output logic signed [14:0] y);
      int r;
      r = $urandom_range(99);
      m = $urandom_range(12, 1);
      d = $urandom_range(28, 1);
      y = $urandom_range(gdnc_pkg::YEAR_MAX - gdnc_pkg::YEAR_MIN) + gdnc_pkg::YEAR_MIN;
      if (r < 5) begin
         m = $urandom;
         d = $urandom;
         y = $urandom;
      end else begin
         if (r < 10) d = $urandom_range(31);
         else if (r < 40) d = $urandom_range(31, 28);
         if (r >= 85 && r < 92) y = $urandom_range(9) + gdnc_pkg::YEAR_MIN;
         else if (r >= 92) y = gdnc_pkg::YEAR_MAX - $urandom_range(9);
      end
   endtask

   task automatic random_word();
      gdnc_pkg::op_type   op;
      logic [3:0]         m, mb;
      logic [4:0]         d, db;
      logic signed [14:0] y, yb;
      logic signed [22:0] cnt;
      longint             target;
      op = gdnc_pkg::op_type'($urandom_range(3));
      random_date(m, d, y);
      random_date(mb, db, yb);
      if (op == gdnc_pkg::OP_DIFF && $urandom_range(6) == 0) begin
         mb = m;
         db = d;
         yb = y;
      end
      cnt = $urandom;
      if (op == gdnc_pkg::OP_TO_DATE && $urandom_range(9) < 7) begin
         target = longint'($urandom_range(gdnc_pkg::JDN_HI - gdnc_pkg::JDN_LO)) +
                  longint'(gdnc_pkg::JDN_LO) - longint'(current_epoch);
         if (target >= -4194304 && target <= 4194303) cnt = target;
      end else if (op == gdnc_pkg::OP_ADD_DAYS && $urandom_range(9) < 7) begin
         cnt = $urandom_range(800000) - 400000;
      end
      send_word(op, m, d, y, cnt, mb, db, yb);
   endtask

   task automatic random_words(input int n);
      int burst;
      while (n > 0) begin
         burst = $urandom_range(24, 1);
         if (burst > n) burst = n;
         repeat (burst) random_word();
         n = n - burst;
         if ($urandom_range(3) != 0) idle($urandom_range(10, 1));
      end
   endtask

   initial begin : stimulus
      logic [31:0] v;
      reset = 1'b1;
      start = 1'b0;
      req_opcode = '0;
      req_month = '0;
      req_day = '0;
      req_year = '0;
      req_day_count_in = '0;
      req_month_b = '0;
      req_day_b = '0;
      req_year_b = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      current_epoch = gdnc_pkg::EPOCH_RESET;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      directed_words();
      edge_words();
      random_words(WORDS_PER_PHASE);
      for (int phase = 0; phase < 4; phase++) begin
         v = $urandom;
         unique case (phase)
            0: v[21:0] = '0;
            1: v[21:0] = '1;
            3: v[21:0] = gdnc_pkg::EPOCH_RESET;
            default: ;
         endcase
         drain();
         load_epoch(v);
         edge_words();
         random_words(WORDS_PER_PHASE);
      end

      drain();
      repeat (gdnc_pkg::RSP_DELAY + 4) @(negedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/gdnc_pkg.sv
rtl/gregorian_day_number_converter.sv
dv/gdnc_checker.sv
dv/tb.sv
